// ===== hw/rtl/fdl_pkg.sv =====
// ----------------------------------------------------------------------------
// fdl_pkg: shared types and constants for the feedback delay line
// Sample, gain and limit widths, register indexes and the access flag struct.
// ----------------------------------------------------------------------------
package fdl_pkg;

  localparam int SAMPLE_W      = 24;   // Q4.19 signed samples
  localparam int DELAY_W       = 17;
  localparam int GAIN_W        = 17;   // Q1.16 unsigned
  localparam int LIMIT_W       = 23;   // Q4.19 unsigned magnitude
  localparam int CFG_W         = 23;   // widest register
  localparam int CFG_IDX_W     = 2;
  localparam int PROD_W        = 42;   // sample x gain, with sign headroom
  localparam int FB_SHIFT      = 16;
  localparam int MAX_DELAY_DEF = 65536;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'd524288;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY = 2'd0,
    REG_GAIN  = 2'd1,
    REG_LIMIT = 2'd2
  } cfg_reg_t;

  // per-item access info from the position tracker
  typedef struct packed {
    logic bypass;   // delay length is zero: pass input through
    logic fresh;    // entry never touched since reset: reads as zero
  } acc_flags_t;

endpackage

// ===== hw/rtl/fdl_store.sv =====
// ----------------------------------------------------------------------------
// fdl_store: echo sample memory
// One write port and one registered read port with a read enable. A read and
// a write to the same entry in one cycle return the old contents.
// ----------------------------------------------------------------------------
module fdl_store import fdl_pkg::*; #(
  parameter int DEPTH = MAX_DELAY_DEF,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output sample_t       rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  sample_t       wr_data
);

  sample_t mem [DEPTH];

  // read holds its data while no new read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ===== hw/rtl/fdl_addr.sv =====
// ----------------------------------------------------------------------------
// fdl_addr: circular position and fill count
// Wraps the position at the effective delay length and keeps a high-water
// mark of touched entries, so entries beyond it read as zero after reset.
// ----------------------------------------------------------------------------
module fdl_addr import fdl_pkg::*; #(
  parameter int MAX_DELAY = MAX_DELAY_DEF,
  parameter int AW        = 16,
  parameter int PW        = 17
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               acc,
  input  logic [DELAY_W-1:0] delay_samples,
  output logic [AW-1:0]      pos,
  output acc_flags_t         flags
);

  localparam logic [31:0] MAX32 = 32'(MAX_DELAY);

  logic [PW-1:0] position;
  logic [PW-1:0] fill;
  logic [31:0]   len;
  logic [PW-1:0] cur;

  // effective length and wrapped position
  always_comb begin
    len          = (32'(delay_samples) > MAX32) ? MAX32 : 32'(delay_samples);
    cur          = (32'(position) >= len) ? '0 : position;
    pos          = cur[AW-1:0];
    flags.bypass = (delay_samples == '0);
    flags.fresh  = (cur == fill);
  end

  // advance on each non-bypass item
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      fill     <= '0;
    end else if (acc && !flags.bypass) begin
      position <= cur + 1'b1;
      if (flags.fresh) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // every entry below the fill mark has been reached in order
  a_pos_le_fill: assert property (@(posedge clk) disable iff (rst)
    position <= fill) else $error("position beyond fill mark");

  a_fill_le_max: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= MAX32) else $error("fill mark beyond store depth");

  a_bypass_hold: assert property (@(posedge clk) disable iff (rst)
    acc && flags.bypass |=> $stable(position) && $stable(fill))
    else $error("bypass item moved the position");

endmodule

// ===== hw/rtl/fdl_fb.sv =====
// ----------------------------------------------------------------------------
// fdl_fb: feedback sum
// Rounds the Q5.35 feedback product to Q5.19 (half up), adds the input and
// clamps the sum to plus or minus the limit.
// ----------------------------------------------------------------------------
module fdl_fb import fdl_pkg::*; (
  input  logic signed [PROD_W-1:0] prod,
  input  sample_t                  x,
  input  logic [LIMIT_W-1:0]       lim,
  output sample_t                  result
);

  localparam int FB_W  = PROD_W - FB_SHIFT;
  localparam int SUM_W = FB_W + 1;

  logic signed [PROD_W-1:0] rnd;
  logic signed [FB_W-1:0]   fb;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  hi;
  logic signed [SUM_W-1:0]  lo;

  always_comb begin
    rnd = prod + PROD_W'(32768);
    fb  = rnd[PROD_W-1:FB_SHIFT];
    sum = SUM_W'(x) + SUM_W'(fb);
    hi  = $signed({{(SUM_W-LIMIT_W){1'b0}}, lim});
    lo  = -hi;
    // clamp to the symmetric limit
    if (sum > hi) begin
      result = hi[SAMPLE_W-1:0];
    end else if (sum < lo) begin
      result = lo[SAMPLE_W-1:0];
    end else begin
      result = sum[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/feedback_delay_line.sv =====
// ----------------------------------------------------------------------------
// feedback_delay_line: audio echo (feedback comb filter)
// One sample in, one sample out; the store is updated with the clamped sum
// of the input and the rounded feedback of the sample read out.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on in_valid/in_ready with sample_in and leave on
//   out_valid/out_ready with sample_out, one result per item, in order.
//   Registers are written through cfg_wen/cfg_index/cfg_wdata while the
//   block is idle: 0 delay length (0 = bypass), 1 feedback gain Q1.16,
//   2 clamp limit Q4.19.
//   Items pass stage A, stage B and the output register. Throughput is one
//   item per cycle while the output is not stalled; with a delay length
//   of one, consecutive items hit the same store entry and the read waits
//   for the write. The multiplier and the feedback sum each get a stage.
//   Reset clears the pipeline, position, delay length and gain and sets
//   the clamp limit to 1.0. The store is not swept: a fill mark makes entries
//   never touched since reset read as zero; items are taken right after reset.
//   When the receiver stalls, the output register holds its item; items still
//   flow into stages B and A until each holds one; then in_ready drops.
// ----------------------------------------------------------------------------
module feedback_delay_line import fdl_pkg::*; #(
  parameter int MAX_DELAY = MAX_DELAY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sample_t              sample_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sample_t              sample_out
);

  localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int PW = $clog2(MAX_DELAY + 1);

  // configuration
  logic [DELAY_W-1:0] delay_samples;
  logic [GAIN_W-1:0]  feedback_gain;
  logic [LIMIT_W-1:0] clamp_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= '0;
      feedback_gain <= '0;
      clamp_limit   <= LIMIT_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_DELAY: delay_samples <= cfg_wdata[DELAY_W-1:0];
        REG_GAIN:  feedback_gain <= cfg_wdata[GAIN_W-1:0];
        REG_LIMIT: clamp_limit   <= cfg_wdata[LIMIT_W-1:0];
        default:   ;
      endcase
    end
  end

  // pipeline control
  logic in_acc, a_go, b_go, a_free, b_free, out_free, hazard;

  logic          a_valid;
  logic [AW-1:0] a_pos;
  sample_t       a_x;
  acc_flags_t    a_flags;
  logic          a_fwd_v;
  sample_t       a_fwd;
  sample_t       a_stored;
  logic signed [PROD_W-1:0] a_prod;

  logic          b_valid;
  logic [AW-1:0] b_pos;
  sample_t       b_x;
  logic          b_bypass;
  sample_t       b_stored;
  logic signed [PROD_W-1:0] b_prod;

  logic [AW-1:0] acc_pos;
  acc_flags_t    acc_flags;
  sample_t       rd_data;
  sample_t       wr_data;
  logic          wr_en;

  fdl_addr #(.MAX_DELAY(MAX_DELAY), .AW(AW), .PW(PW)) u_addr (
    .clk           (clk),
    .rst           (rst),
    .acc           (in_acc),
    .delay_samples (delay_samples),
    .pos           (acc_pos),
    .flags         (acc_flags)
  );

  fdl_store #(.DEPTH(MAX_DELAY), .AW(AW)) u_store (
    .clk     (clk),
    .rd_en   (in_acc && !acc_flags.bypass),
    .rd_addr (acc_pos),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (b_pos),
    .wr_data (wr_data)
  );

  fdl_fb u_fb (
    .prod   (b_prod),
    .x      (b_x),
    .lim    (clamp_limit),
    .result (wr_data)
  );

  // handshakes; stage A waits while B still owes a write to its entry
  always_comb begin
    hazard   = a_valid && !a_flags.bypass && b_valid && !b_bypass && (b_pos == a_pos);
    out_free = !out_valid || out_ready;
    b_go     = b_valid && out_free;
    b_free   = !b_valid || b_go;
    a_go     = a_valid && b_free && !hazard;
    a_free   = !a_valid || a_go;
    in_ready = a_free;
    in_acc   = in_valid && in_ready;
    wr_en    = b_go && !b_bypass;
  end

  // stored value: forwarded write, zero for untouched entries, else memory
  always_comb begin
    if (a_fwd_v) begin
      a_stored = a_fwd;
    end else if (a_flags.fresh) begin
      a_stored = '0;
    end else begin
      a_stored = rd_data;
    end
    a_prod = PROD_W'(a_stored) * PROD_W'($signed({1'b0, feedback_gain}));
  end

  // stage A: read issued at accept, snoop writes to the held entry
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_fwd_v <= 1'b0;
    end else begin
      if (in_acc) begin
        a_valid <= 1'b1;
      end else if (a_go) begin
        a_valid <= 1'b0;
      end
      if (in_acc) begin
        a_fwd_v <= wr_en && (b_pos == acc_pos);
      end else if (a_go) begin
        a_fwd_v <= 1'b0;
      end else if (a_valid && wr_en && (b_pos == a_pos)) begin
        a_fwd_v <= 1'b1;
      end
    end
    if (in_acc) begin
      a_pos   <= acc_pos;
      a_x     <= sample_in;
      a_flags <= acc_flags;
    end
    if (wr_en) begin
      a_fwd <= wr_data;
    end
  end

  // stage B: product registered, output value carried along
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_go) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
    if (a_go) begin
      b_pos    <= a_pos;
      b_x      <= a_x;
      b_bypass <= a_flags.bypass;
      b_stored <= a_flags.bypass ? a_x : a_stored;
      b_prod   <= a_prod;
    end
  end

  // output register; the store write happens as the item leaves B
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (b_go) begin
      sample_out <= b_stored;
    end
  end

  a_no_raw: assert property (@(posedge clk) disable iff (rst)
    !(a_go && !a_flags.bypass && b_valid && !b_bypass && (b_pos == a_pos)))
    else $error("stage A passed an entry with a write still pending");

  a_fwd_owner: assert property (@(posedge clk) disable iff (rst)
    a_fwd_v |-> a_valid) else $error("forward flag set with stage A empty");

  a_wr_then_fwd: assert property (@(posedge clk) disable iff (rst)
    wr_en && a_valid && !a_go && (b_pos == a_pos) |=> a_fwd_v)
    else $error("write to held entry not forwarded");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the feedback delay line
// Streams samples through the echo block under changing delay, gain and
// limit settings. A scoreboard class keeps its own copy of the echo store
// and predicts every output sample in order. Sender gaps and receiver stalls
// are random.
// ----------------------------------------------------------------------------
import fdl_pkg::*;

// Predicts the echo output and checks returned samples in order
class echo_tracker;
  bit [SAMPLE_W-1:0] echo_mem [MAX_DELAY_DEF];
  int unsigned       tap = 0;
  bit [DELAY_W-1:0]  delay_len = '0;
  bit [GAIN_W-1:0]   gain = '0;
  bit [LIMIT_W-1:0]  limit = LIMIT_RESET;
  sample_t           due_samples[$];
  int                errors = 0;

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    unique case (idx)
      REG_DELAY: delay_len = data[DELAY_W-1:0];
      REG_GAIN:  gain      = data[GAIN_W-1:0];
      REG_LIMIT: limit     = data[LIMIT_W-1:0];
      default:   ;  // no register here, write dropped
    endcase
  endfunction

  // Accepted input: queue the sample it will produce, update the store unless bypassed
  function void take_sample(sample_t x);
    int unsigned len;
    longint      stored;
    longint      fb;
    longint      sum;
    longint      lim;
    if (delay_len == 0) begin
      due_samples.push_back(x);
      return;
    end
    len = (delay_len > MAX_DELAY_DEF) ? MAX_DELAY_DEF : delay_len;
    if (tap >= len) tap = 0;
    stored = longint'(sample_t'(echo_mem[tap]));
    due_samples.push_back(sample_t'(echo_mem[tap]));
    // Q5.35 product rounded half up back to Q5.19
    fb  = (stored * longint'(gain) + 32768) >>> FB_SHIFT;
    sum = longint'(x) + fb;
    lim = longint'(limit);
    if (sum > lim)  sum = lim;
    if (sum < -lim) sum = -lim;
    echo_mem[tap] = sum[SAMPLE_W-1:0];
    tap++;
  endfunction

  function void check_sample(sample_t got);
    sample_t want;
    if (due_samples.size() == 0) begin
      $display("%0t: unexpected sample_out, expected none, got %0d", $time, got);
      errors++;
      return;
    end
    want = due_samples.pop_front();
    if (got !== want) begin
      $display("%0t: sample_out mismatch, expected %0d, got %0d", $time, want, got);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int                   CYCLE_LIMIT  = 300000;
  localparam int                   RANDOM_ITEMS = 450;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;  // no register at this index
  localparam sample_t              SAMPLE_MAX   = 24'sh7FFFFF;
  localparam sample_t              SAMPLE_MIN   = 24'sh800000;
  localparam int                   GAIN_MAX     = 131071;
  localparam int                   LIMIT_MAX    = 8388607;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  sample_t              sample_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  sample_t              sample_out;

  echo_tracker sb = new();
  int          cycle_count = 0;
  int          ready_run = 0;
  int          burst_left = 0;
  int          sent_count = 0;

  feedback_delay_line i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: ready runs broken by short stalls, now and then a long one
  always @(posedge clk) begin
    if (ready_run == 0) begin
      if (out_ready) begin
        out_ready <= 1'b0;
        ready_run <= ($urandom_range(0, 15) == 0) ? 20 : $urandom_range(1, 6);
      end else begin
        out_ready <= 1'b1;
        ready_run <= $urandom_range(1, 40);
      end
    end else begin
      ready_run <= ready_run - 1;
    end
  end

  // Handshake monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)   sb.take_sample(sample_in);
      if (out_valid && out_ready) sb.check_sample(sample_out);
    end
  end

  // Called right after the clock rises; returns once the item has been taken
  task automatic send_sample(sample_t x);
    in_valid  <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_input(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Bursty sender: random gap before each new burst
  task automatic feed_one(sample_t x);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) pause_input(gap);
      burst_left = $urandom_range(1, 24);
    end
    send_sample(x);
    burst_left--;
    sent_count++;
  endtask

  // Drain: valid low, all outputs back, then pipeline latency
  task automatic wait_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.due_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Write the registers picked by sel, junk bits above the delay and gain fields; junk also writes the unused index
  task automatic configure(bit [2:0] sel, int dly, int gn, int lim, bit junk);
    logic [CFG_W-DELAY_W-1:0] upper;
    upper = (CFG_W-DELAY_W)'($urandom());
    if (sel[0]) cfg_write(REG_DELAY, {upper, dly[DELAY_W-1:0]});
    upper = (CFG_W-DELAY_W)'($urandom());
    if (sel[1]) cfg_write(REG_GAIN, {upper, gn[GAIN_W-1:0]});
    if (sel[2]) cfg_write(REG_LIMIT, lim[LIMIT_W-1:0]);
    if (junk)   cfg_write(REG_UNUSED, CFG_W'($urandom()));
    cfg_wen <= 1'b0;
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SAMPLE_W'(int'($urandom_range(0, 2000)) - 1000);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic int rand_delay();
    case ($urandom_range(0, 19))
      0:          return 0;
      1:          return $urandom_range(65537, 131071);
      2:          return MAX_DELAY_DEF;
      3:          return $urandom_range(100, 65535);
      4, 5, 6:    return 1;
      default:    return $urandom_range(2, 12);
    endcase
  endfunction

  function automatic int rand_gain();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 65536;
      2:       return GAIN_MAX;
      3:       return $urandom_range(0, GAIN_MAX);
      default: return $urandom_range(30000, 70000);
    endcase
  endfunction

  function automatic int rand_limit();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return LIMIT_MAX;
      2:       return LIMIT_RESET;
      3:       return $urandom_range(1, 4096);
      default: return $urandom_range(0, LIMIT_MAX);
    endcase
  endfunction

  initial begin
    int n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: bypass, field extremes
    feed_one(SAMPLE_MAX);
    feed_one(SAMPLE_MIN);
    feed_one(0);
    feed_one(-1);

    // One-sample delay, unity gain: read follows write on one entry
    wait_idle();
    configure(3'b011, 1, 65536, 0, 1'b1);
    feed_one(SAMPLE_MAX);
    feed_one(SAMPLE_MIN);
    feed_one(1000);
    feed_one(0);

    // Delay beyond the store, top gain, widest limit
    wait_idle();
    configure(3'b111, GAIN_MAX, GAIN_MAX, LIMIT_MAX, 1'b0);
    feed_one(SAMPLE_MAX);
    feed_one(SAMPLE_MIN);
    feed_one(12345);

    // Shorter length: position wraps onto old entries, gain above one
    wait_idle();
    configure(3'b001, 2, 0, 0, 1'b0);
    feed_one(4000000);
    feed_one(-3000000);
    feed_one(4000000);
    feed_one(-3000000);
    feed_one(7);

    // Zero limit and zero gain wipe what is stored
    wait_idle();
    configure(3'b111, 3, 0, 0, 1'b0);
    feed_one(5);
    feed_one(-5);
    feed_one(SAMPLE_MAX);
    feed_one(1);

    // Back to bypass; store and position must survive
    wait_idle();
    configure(3'b001, 0, 0, 0, 1'b0);
    feed_one(SAMPLE_MIN);
    feed_one(42);

    // Random settings, random content
    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      wait_idle();
      configure(3'($urandom_range(1, 7)), rand_delay(), rand_gain(), rand_limit(),
                $urandom_range(0, 4) == 0);
      n = $urandom_range(15, 50);
      repeat (n) feed_one(rand_sample());
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
